// File: hw/rtl/aarm_pkg.sv
package aarm_pkg;

  // defaults for the top level parameters
  localparam int DATA_BITS_DEF  = 16;
  localparam int ANGLE_BITS_DEF = 16;

  // cordic datapath: q30 vector, 32-bit binary angle
  localparam int CORDIC_STEPS = 30;
  localparam int CORDIC_W     = 32;
  localparam int CORDIC_FRAC  = 30;

  typedef logic signed [CORDIC_W-1:0] cordic_word_t;

  // inverse cordic gain, q30
  localparam cordic_word_t CORDIC_GAIN = 32'sd652032874;

  typedef logic [CORDIC_W-1:0] atan_tab_t [CORDIC_STEPS];

  // arctangent of 2^-i in 32-bit binary angle units, truncated
  localparam atan_tab_t ATAN_TAB = '{
    32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
    32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001
  };

  // per-stage pipeline control
  typedef struct packed {
    logic en;
    logic vld;
  } stage_ctrl_t;

endpackage

// File: hw/rtl/aarm_cordic_cell.sv
module aarm_cordic_cell #(
  parameter int STEP   = 0,
  parameter int SIDE_W = 49
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  aarm_pkg::stage_ctrl_t ctrl_i,
  input  aarm_pkg::cordic_word_t cx_i,
  input  aarm_pkg::cordic_word_t cy_i,
  input  aarm_pkg::cordic_word_t cz_i,
  input  logic [SIDE_W-1:0]    side_i,
  output logic                 vld_o,
  output aarm_pkg::cordic_word_t cx_o,
  output aarm_pkg::cordic_word_t cy_o,
  output aarm_pkg::cordic_word_t cz_o,
  output logic [SIDE_W-1:0]    side_o
);
  import aarm_pkg::*;

  logic              vld_r;
  cordic_word_t      cx_r, cy_r, cz_r;
  cordic_word_t      cx_nxt, cy_nxt, cz_nxt;
  cordic_word_t      dx, dy;
  logic [SIDE_W-1:0] side_r;

  // one micro-rotation, direction from the sign of the residual angle
  always_comb begin
    dx = cy_i >>> STEP;
    dy = cx_i >>> STEP;
    if (!cz_i[CORDIC_W-1]) begin
      cx_nxt = cx_i - dx;
      cy_nxt = cy_i + dy;
      cz_nxt = cz_i - cordic_word_t'(ATAN_TAB[STEP]);
    end else begin
      cx_nxt = cx_i + dx;
      cy_nxt = cy_i - dy;
      cz_nxt = cz_i + cordic_word_t'(ATAN_TAB[STEP]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (ctrl_i.en) begin
      vld_r <= ctrl_i.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl_i.en) begin
      cx_r   <= cx_nxt;
      cy_r   <= cy_nxt;
      cz_r   <= cz_nxt;
      side_r <= side_i;
    end
  end

  assign vld_o  = vld_r;
  assign cx_o   = cx_r;
  assign cy_o   = cy_r;
  assign cz_o   = cz_r;
  assign side_o = side_r;

endmodule

// File: hw/rtl/aarm_rodrigues.sv
module aarm_rodrigues #(
  parameter int DATA_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     vld_i,
  input  aarm_pkg::cordic_word_t   cx_i,
  input  aarm_pkg::cordic_word_t   cy_i,
  input  logic [3*DATA_BITS:0]     side_i,
  output logic                     vld_o,
  output logic [9*DATA_BITS-1:0]   data_o
);
  import aarm_pkg::*;

  localparam int D  = DATA_BITS;
  localparam int FD = D - 2;
  localparam int SH = CORDIC_FRAC - FD;

  typedef logic signed [CORDIC_W:0] cwide_t;
  typedef logic signed [D-1:0]      d_t;
  typedef logic signed [D:0]        a_t;
  typedef logic signed [D+1:0]      pair_t;
  typedef logic signed [D+2:0]      pa_t;
  typedef logic signed [D+3:0]      sum_t;
  typedef logic signed [2*D:0]      m1_t;
  typedef logic signed [2*D+3:0]    m2_t;

  localparam cwide_t RND_HALF = (SH == 0) ? cwide_t'(0) :
                                (cwide_t'(1) <<< ((SH == 0) ? 0 : SH - 1));
  localparam cwide_t ONE_W    = cwide_t'(1) <<< FD;
  localparam a_t     ONE_A    = a_t'(1) <<< FD;
  localparam m1_t    M1_HALF  = m1_t'(1) <<< (FD - 1);
  localparam m2_t    M2_HALF  = m2_t'(1) <<< (FD - 1);
  localparam sum_t   SAT_HI   = (sum_t'(1) <<< (D - 1)) - sum_t'(1);
  localparam sum_t   SAT_LO   = -SAT_HI - sum_t'(1);

  // q30 to q fd, round half up, clamp to +-1.0
  function automatic d_t to_fd(input cwide_t v);
    cwide_t r;
    r = (v + RND_HALF) >>> SH;
    if (r > ONE_W) begin
      r = ONE_W;
    end else if (r < -ONE_W) begin
      r = -ONE_W;
    end
    return d_t'(r);
  endfunction

  // q fd times q fd, rounded half away from zero
  function automatic pair_t mul_dd(input d_t p, input d_t q);
    m1_t m;
    m1_t t;
    m = m1_t'(p) * m1_t'(q);
    t = (m + M1_HALF - m1_t'(m[2*D])) >>> FD;
    return pair_t'(t);
  endfunction

  function automatic pa_t mul_pa(input pair_t p, input a_t q);
    m2_t m;
    m2_t t;
    m = m2_t'(p) * m2_t'(q);
    t = (m + M2_HALF - m2_t'(m[2*D+3])) >>> FD;
    return pa_t'(t);
  endfunction

  function automatic d_t sat(input sum_t v);
    sum_t r;
    r = v;
    if (r > SAT_HI) begin
      r = SAT_HI;
    end else if (r < SAT_LO) begin
      r = SAT_LO;
    end
    return d_t'(r);
  endfunction

  d_t     ax, ay, az;
  logic   flip;
  cwide_t cx_f, cy_f;

  assign ax   = d_t'(side_i[D-1:0]);
  assign ay   = d_t'(side_i[2*D-1:D]);
  assign az   = d_t'(side_i[3*D-1:2*D]);
  assign flip = side_i[3*D];

  // angle was folded by pi ahead of the cordic
  assign cx_f = flip ? -cwide_t'(cx_i) : cwide_t'(cx_i);
  assign cy_f = flip ? -cwide_t'(cy_i) : cwide_t'(cy_i);

  // stage 1: sine, cosine, axis pair products
  logic  vld1_r;
  d_t    c1_r, s1_r, x1_r, y1_r, z1_r;
  pair_t pxx1_r, pxy1_r, pxz1_r, pyy1_r, pyz1_r, pzz1_r;

  // stage 2: scaled pair products and sine terms
  logic  vld2_r;
  d_t    c2_r;
  a_t    a1;
  pa_t   pxx2_r, pxy2_r, pxz2_r, pyy2_r, pyz2_r, pzz2_r;
  pair_t xs2_r, ys2_r, zs2_r;

  // stage 3: saturated matrix entries
  logic  vld3_r;
  d_t    r11_nxt, r12_nxt, r13_nxt, r21_nxt, r22_nxt;
  d_t    r23_nxt, r31_nxt, r32_nxt, r33_nxt;
  logic [9*D-1:0] data3_r;

  assign a1 = ONE_A - a_t'(c1_r);

  always_comb begin
    r11_nxt = sat(sum_t'(pxx2_r) + sum_t'(c2_r));
    r12_nxt = sat(sum_t'(pxy2_r) + sum_t'(zs2_r));
    r13_nxt = sat(sum_t'(pxz2_r) - sum_t'(ys2_r));
    r21_nxt = sat(sum_t'(pxy2_r) - sum_t'(zs2_r));
    r22_nxt = sat(sum_t'(pyy2_r) + sum_t'(c2_r));
    r23_nxt = sat(sum_t'(pyz2_r) + sum_t'(xs2_r));
    r31_nxt = sat(sum_t'(pxz2_r) + sum_t'(ys2_r));
    r32_nxt = sat(sum_t'(pyz2_r) - sum_t'(xs2_r));
    r33_nxt = sat(sum_t'(pzz2_r) + sum_t'(c2_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
    end else if (en) begin
      vld1_r <= vld_i;
      vld2_r <= vld1_r;
      vld3_r <= vld2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1_r   <= to_fd(cx_f);
      s1_r   <= to_fd(cy_f);
      x1_r   <= ax;
      y1_r   <= ay;
      z1_r   <= az;
      pxx1_r <= mul_dd(ax, ax);
      pxy1_r <= mul_dd(ax, ay);
      pxz1_r <= mul_dd(ax, az);
      pyy1_r <= mul_dd(ay, ay);
      pyz1_r <= mul_dd(ay, az);
      pzz1_r <= mul_dd(az, az);

      c2_r   <= c1_r;
      pxx2_r <= mul_pa(pxx1_r, a1);
      pxy2_r <= mul_pa(pxy1_r, a1);
      pxz2_r <= mul_pa(pxz1_r, a1);
      pyy2_r <= mul_pa(pyy1_r, a1);
      pyz2_r <= mul_pa(pyz1_r, a1);
      pzz2_r <= mul_pa(pzz1_r, a1);
      xs2_r  <= mul_dd(x1_r, s1_r);
      ys2_r  <= mul_dd(y1_r, s1_r);
      zs2_r  <= mul_dd(z1_r, s1_r);

      data3_r <= {r33_nxt, r32_nxt, r31_nxt, r23_nxt, r22_nxt,
                  r21_nxt, r13_nxt, r12_nxt, r11_nxt};
    end
  end

  assign vld_o  = vld3_r;
  assign data_o = data3_r;

endmodule

// File: hw/rtl/aarm_out_skid.sv
module aarm_out_skid #(
  parameter int W = 144
) (
  input  logic         clk,
  input  logic         rst_n,
  output logic         pipe_en,
  input  logic         vld_i,
  input  logic [W-1:0] data_i,
  output logic         m_vld,
  output logic [W-1:0] m_data,
  input  logic         m_ready
);

  logic         out_vld_r, out_vld_nxt;
  logic         skid_vld_r, skid_vld_nxt;
  logic [W-1:0] out_data_r, out_data_nxt;
  logic [W-1:0] skid_data_r, skid_data_nxt;
  logic         arrive;

  // pipeline moves only while the skid slot is free
  assign pipe_en = !skid_vld_r;
  assign arrive  = vld_i && !skid_vld_r;

  always_comb begin
    out_vld_nxt   = out_vld_r;
    skid_vld_nxt  = skid_vld_r;
    out_data_nxt  = out_data_r;
    skid_data_nxt = skid_data_r;
    if (skid_vld_r) begin
      if (m_ready) begin
        out_data_nxt = skid_data_r;
        skid_vld_nxt = 1'b0;
      end
    end else if (!out_vld_r || m_ready) begin
      out_vld_nxt  = arrive;
      out_data_nxt = data_i;
    end else if (arrive) begin
      skid_vld_nxt  = 1'b1;
      skid_data_nxt = data_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign m_vld  = out_vld_r;
  assign m_data = out_data_r;

endmodule

// File: hw/rtl/axis_angle_rotation_matrix.sv
// pipeline: 30 cordic cells, three product and sum stages, output register
// throughput: one request per cycle while in_tready is high, set by the
//   pipelined cordic cell chain
// in_tready falls only when the output register and the skid slot both hold
//   results; it is a register output, not a function of out_tready
// reset: synchronous, active low; clears all valid flags, data path is not reset
module axis_angle_rotation_matrix #(
  parameter int DATA_BITS  = aarm_pkg::DATA_BITS_DEF,
  parameter int ANGLE_BITS = aarm_pkg::ANGLE_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  // request channel
  input  logic in_tvalid,
  output logic in_tready,
  // axis_x, axis_y, axis_z, angle; zero padded to whole bytes
  input  logic [((3*DATA_BITS+ANGLE_BITS+7)/8)*8-1:0] in_tdata,
  // result channel
  output logic out_tvalid,
  input  logic out_tready,
  // r11, r12, r13, r21, r22, r23, r31, r32, r33; zero padded to whole bytes
  output logic [((9*DATA_BITS+7)/8)*8-1:0] out_tdata
);
  import aarm_pkg::*;

  localparam int OUT_W  = ((9*DATA_BITS+7)/8)*8;
  localparam int RES_W  = 9*DATA_BITS;
  localparam int SIDE_W = 3*DATA_BITS + 1;
  localparam int ANG_SH = CORDIC_W - ANGLE_BITS;

  // pipeline advance, shared by every cordic cell and rodrigues stage
  logic pipe_en;

  // angle folding into [-pi/2, pi/2)
  logic [ANGLE_BITS-1:0] ang;
  logic [CORDIC_W-1:0]   ang_w;
  logic                  flip;
  logic [CORDIC_W-1:0]   ang_fold;

  assign ang      = in_tdata[3*DATA_BITS +: ANGLE_BITS];
  assign ang_w    = CORDIC_W'(ang) << ANG_SH;
  // angle in [pi/2, 3pi/2) when the top two bits differ
  assign flip     = ang_w[CORDIC_W-1] ^ ang_w[CORDIC_W-2];
  assign ang_fold = {ang_w[CORDIC_W-1] ^ flip, ang_w[CORDIC_W-2:0]};

  // cell chain wiring, index k feeds cell k
  logic              vld_w  [CORDIC_STEPS+1];
  cordic_word_t      cx_w   [CORDIC_STEPS+1];
  cordic_word_t      cy_w   [CORDIC_STEPS+1];
  cordic_word_t      cz_w   [CORDIC_STEPS+1];
  logic [SIDE_W-1:0] side_w [CORDIC_STEPS+1];
  stage_ctrl_t       ctrl_w [CORDIC_STEPS];

  // the chain starts from the gain on the x axis
  assign vld_w[0]  = in_tvalid;
  assign cx_w[0]   = CORDIC_GAIN;
  assign cy_w[0]   = '0;
  assign cz_w[0]   = cordic_word_t'(ang_fold);
  // axis components ride along with the fold flag on top
  assign side_w[0] = {flip, in_tdata[3*DATA_BITS-1:0]};

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cell
    assign ctrl_w[k] = '{en: pipe_en, vld: vld_w[k]};

    aarm_cordic_cell #(
      .STEP   (k),
      .SIDE_W (SIDE_W)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctrl_i (ctrl_w[k]),
      .cx_i   (cx_w[k]),
      .cy_i   (cy_w[k]),
      .cz_i   (cz_w[k]),
      .side_i (side_w[k]),
      .vld_o  (vld_w[k+1]),
      .cx_o   (cx_w[k+1]),
      .cy_o   (cy_w[k+1]),
      .cz_o   (cz_w[k+1]),
      .side_o (side_w[k+1])
    );
  end

  // rodrigues products and sums
  logic             res_vld;
  logic [RES_W-1:0] res_data;

  aarm_rodrigues #(
    .DATA_BITS (DATA_BITS)
  ) u_rod (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (pipe_en),
    .vld_i  (vld_w[CORDIC_STEPS]),
    .cx_i   (cx_w[CORDIC_STEPS]),
    .cy_i   (cy_w[CORDIC_STEPS]),
    .side_i (side_w[CORDIC_STEPS]),
    .vld_o  (res_vld),
    .data_o (res_data)
  );

  // output register plus skid slot
  logic [RES_W-1:0] out_res;

  aarm_out_skid #(
    .W (RES_W)
  ) u_skid (
    .clk     (clk),
    .rst_n   (rst_n),
    .pipe_en (pipe_en),
    .vld_i   (res_vld),
    .data_i  (res_data),
    .m_vld   (out_tvalid),
    .m_data  (out_res),
    .m_ready (out_tready)
  );

  assign in_tready = pipe_en;
  assign out_tdata = OUT_W'(out_res);

endmodule

// File: hw/rtl/aarm_checker.sv
module aarm_checker #(
  parameter int OUT_W = 144
) (
  input logic             clk,
  input logic             rst_n,
  input logic             in_tready,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // reset empties the output side
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // back pressure only while a result is pending
  a_stall_has_out: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("request side stalled with empty output");

  // the skid slot fills only behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_tready) |-> $past(out_tvalid && !out_tready))
    else $error("request side stalled without output stall");

  // stall lasts no longer than the output stall
  a_stall_release: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready && out_tready |=> in_tready)
    else $error("request side stuck after output drained");

endmodule

bind axis_angle_rotation_matrix aarm_checker #(
  .OUT_W (OUT_W)
) u_aarm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// File: test/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import aarm_pkg::*;

  // block sizes, taken from the package defaults
  localparam int DW = DATA_BITS_DEF;
  localparam int AW = ANGLE_BITS_DEF;
  localparam int FD = DW - 2;
  localparam int IW = ((3*DW + AW + 7)/8)*8;
  localparam int OW = ((9*DW + 7)/8)*8;

  localparam int     RANDOM_REQS   = 1200;
  localparam int     HOLD_CYCLES   = 400;   // long receiver hold-off
  localparam int     QUIET_LIMIT   = 4000;  // cycles with no handshake before giving up
  localparam int     DRAIN_CYCLES  = 60;    // longer than the pipeline is deep
  localparam longint GAIN_Q30      = 652032874;
  localparam longint ONE_FD        = longint'(1) << FD;

  // request fields, axis_x in the lowest bits
  typedef struct packed {
    logic [AW-1:0] angle;
    logic [DW-1:0] az;
    logic [DW-1:0] ay;
    logic [DW-1:0] ax;
  } rot_req_t;

  // matrix entries, r11 in the lowest bits
  typedef struct packed {
    logic [DW-1:0] r33, r32, r31, r23, r22, r21, r13, r12, r11;
  } rot_mat_t;

  logic          clk        = 1'b0;
  logic          rst_n      = 1'b0;
  logic          in_tvalid  = 1'b0;
  logic          in_tready;
  logic [IW-1:0] in_tdata   = '0;
  logic          out_tvalid;
  logic          out_tready = 1'b0;
  logic [OW-1:0] out_tdata;

  // requests waiting to be offered, and matrices waiting to come out
  rot_req_t pending_reqs[$];
  rot_mat_t expected_mats[$];

  int unsigned requests_sent  = 0;
  int unsigned total_requests = 0;
  int unsigned results_seen   = 0;
  int unsigned errors         = 0;
  int unsigned unit_axis_reqs = 0;
  int unsigned holds_done     = 0;

  // arctangent of 2^-i, 32-bit binary angle, truncated
  longint arctan_q32 [0:29] = '{
    'h20000000, 'h12E4051D, 'h09FB385B, 'h051111D4, 'h028B0D43,
    'h0145D7E1, 'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2E,
    'h000A2F98, 'h000517CC, 'h00028BE6, 'h000145F3, 'h0000A2F9,
    'h0000517C, 'h000028BE, 'h0000145F, 'h00000A2F, 'h00000517,
    'h0000028B, 'h00000145, 'h000000A2, 'h00000051, 'h00000028,
    'h00000014, 'h0000000A, 'h00000005, 'h00000002, 'h00000001
  };

  string entry_name [0:8] = '{"r11", "r12", "r13", "r21", "r22", "r23", "r31", "r32", "r33"};

  axis_angle_rotation_matrix #(
    .DATA_BITS (DW),
    .ANGLE_BITS(AW)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #6 clk = ~clk;

  // q30 sine or cosine to q2.fd: round half up, clamp to +-1.0
  function automatic longint q30_to_fd(longint v);
    longint r;
    r = (v + (longint'(1) << (29 - FD))) >>> (30 - FD);
    if (r > ONE_FD) r = ONE_FD;
    if (r < -ONE_FD) r = -ONE_FD;
    return r;
  endfunction

  // product of two q2.fd values back to q2.fd, half away from zero
  function automatic longint fd_mul(longint p, longint q);
    longint m;
    m = (p < 0 ? -p : p) * (q < 0 ? -q : q);
    m = (m + (longint'(1) << (FD - 1))) >>> FD;
    return ((p < 0) != (q < 0)) ? -m : m;
  endfunction

  function automatic logic [DW-1:0] sat_entry(longint v);
    longint hi, lo;
    hi = (longint'(1) << (DW - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return v[DW-1:0];
  endfunction

  // rodrigues matrix for one request: cordic sine/cosine, then the nine entries
  function automatic rot_mat_t rotation_of(rot_req_t rq);
    longint   x, y, z, vx, vy, vz, dx, dy, c, s, a;
    longint   pxx, pxy, pxz, pyy, pyz, pzz, xs, ys, zs;
    logic [31:0] phase, turned;
    bit       flip;
    rot_mat_t m;
    x = longint'($signed(rq.ax));
    y = longint'($signed(rq.ay));
    z = longint'($signed(rq.az));
    phase  = 32'(rq.angle) << (32 - AW);
    // fold the back half-circle onto [-pi/2, pi/2) and negate at the end
    turned = phase + 32'h4000_0000;
    flip   = turned[31];
    if (flip) phase[31] = ~phase[31];
    vz = longint'($signed(phase));
    vx = GAIN_Q30;
    vy = 0;
    for (int i = 0; i < 30; i++) begin
      dx = vy >>> i;
      dy = vx >>> i;
      if (vz >= 0) begin
        vx -= dx; vy += dy; vz -= arctan_q32[i];
      end else begin
        vx += dx; vy -= dy; vz += arctan_q32[i];
      end
    end
    if (flip) begin
      vx = -vx;
      vy = -vy;
    end
    c = q30_to_fd(vx);
    s = q30_to_fd(vy);
    a = ONE_FD - c;
    pxx = fd_mul(fd_mul(x, x), a);
    pxy = fd_mul(fd_mul(x, y), a);
    pxz = fd_mul(fd_mul(x, z), a);
    pyy = fd_mul(fd_mul(y, y), a);
    pyz = fd_mul(fd_mul(y, z), a);
    pzz = fd_mul(fd_mul(z, z), a);
    xs  = fd_mul(x, s);
    ys  = fd_mul(y, s);
    zs  = fd_mul(z, s);
    m.r11 = sat_entry(pxx + c);
    m.r12 = sat_entry(pxy + zs);
    m.r13 = sat_entry(pxz - ys);
    m.r21 = sat_entry(pxy - zs);
    m.r22 = sat_entry(pyy + c);
    m.r23 = sat_entry(pyz + xs);
    m.r31 = sat_entry(pxz + ys);
    m.r32 = sat_entry(pyz - xs);
    m.r33 = sat_entry(pzz + c);
    return m;
  endfunction

  task automatic queue_req(int x, int y, int z, int ang);
    rot_req_t rq;
    rq.ax    = DW'(x);
    rq.ay    = DW'(y);
    rq.az    = DW'(z);
    rq.angle = AW'(ang);
    pending_reqs.push_back(rq);
  endtask

  function automatic int edge_value();
    case ($urandom_range(0, 7))
      0: return -32768;
      1: return 32767;
      2: return -1;
      3: return 0;
      4: return 1;
      5: return 16384;
      6: return -16384;
      default: return -32767;
    endcase
  endfunction

  // driver: offers pending requests in bursts, with random gaps between bursts
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  always @(posedge clk) begin : request_driver
    rot_req_t rq;
    if (rst_n) begin
      // accepted request: work out the matrix it must produce
      if (in_tvalid && in_tready) begin
        rq = rot_req_t'(in_tdata[$bits(rot_req_t)-1:0]);
        expected_mats.push_back(rotation_of(rq));
        requests_sent++;
      end
      // a held request stays on the bus until it is taken
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          in_tdata  <= IW'(pending_reqs.pop_front());
          in_tvalid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 48);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each matrix against the oldest prediction and paces out_tready
  int unsigned hold_left  = 0;
  int unsigned phase_left = 0;
  int unsigned ready_mode = 0;

  always @(posedge clk) begin : result_monitor
    rot_mat_t want, got;
    logic     next_ready;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = rot_mat_t'(out_tdata[$bits(rot_mat_t)-1:0]);
        if (expected_mats.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected matrix %0d with nothing pending: %h", results_seen, got);
        end else begin
          want = expected_mats.pop_front();
          for (int k = 0; k < 9; k++) begin
            if (got[k*DW +: DW] !== want[k*DW +: DW]) begin
              errors++;
              if (errors <= 10)
                $display("matrix %0d %s: expected %0d got %0d", results_seen, entry_name[k],
                         $signed(want[k*DW +: DW]), $signed(got[k*DW +: DW]));
            end
          end
        end
        results_seen++;
      end

      // two long hold-offs so the pipeline fills and stalls the input side
      if (hold_left > 0) begin
        hold_left--;
        next_ready = 1'b0;
      end else if ((holds_done == 0 && results_seen >= 150) ||
                   (holds_done == 1 && results_seen >= 800)) begin
        hold_left  = HOLD_CYCLES;
        holds_done++;
        next_ready = 1'b0;
      end else begin
        if (phase_left == 0) begin
          ready_mode = $urandom_range(0, 3);
          phase_left = $urandom_range(4, 64);
        end
        phase_left--;
        case (ready_mode)
          0, 1:    next_ready = 1'b1;                           // no stalls
          2:       next_ready = 1'($urandom_range(0, 1));
          default: next_ready = ($urandom_range(0, 3) == 0);    // mostly stalled
        endcase
      end
      out_tready <= next_ready;
    end
  end

  // watchdog: too long without any handshake ends the run
  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("timeout after %0d quiet cycles, %0d of %0d requests sent, %0d matrices seen",
             quiet_cycles, requests_sent, total_requests, results_seen);
    $display("testbench: errors");
    $finish;
  end

  initial begin : stimulus
    real rx, ry, rz, len;
    int  ax, ay, az;

    // directed: zero, unit axes at the quadrant angles, extremes, folds
    queue_req(0, 0, 0, 0);
    queue_req(16384, 0, 0, 0);
    queue_req(16384, 0, 0, 16384);      // 90 degrees, start of the folded half
    queue_req(16384, 0, 0, -32768);     // 180 degrees
    queue_req(16384, 0, 0, -16384);     // 270 degrees, just outside the fold
    queue_req(16384, 0, 0, 16383);
    queue_req(16384, 0, 0, -16385);
    queue_req(0, 16384, 0, 16384);
    queue_req(0, 0, 16384, 16384);
    queue_req(0, 0, 16384, 8192);
    queue_req(0, 0, -16384, -8192);
    queue_req(9459, 9459, 9459, 5461);  // diagonal axis
    queue_req(32767, 32767, 32767, 0);  // long axis, saturating entries
    queue_req(32767, 32767, 32767, -32768);
    queue_req(-32768, -32768, -32768, -32768);
    queue_req(-32768, -32768, -32768, 16384);
    queue_req(-32768, 32767, 0, 32767);
    queue_req(32767, -32768, -1, -1);
    queue_req(1, -1, 1, 1);
    queue_req(-1, -1, -1, 32767);
    queue_req(16384, -16384, 16384, -32767);
    queue_req(-16384, 16384, -16384, 12345);

    // random: half unit axes, the rest raw words and edge values
    for (int n = 0; n < RANDOM_REQS; n++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          rx  = $urandom_range(0, 2000) - 1000.0;
          ry  = $urandom_range(0, 2000) - 1000.0;
          rz  = $urandom_range(0, 2000) - 1000.0;
          len = $sqrt(rx*rx + ry*ry + rz*rz);
          if (len < 1.0) begin
            rx  = 1000.0;
            len = 1000.0;
          end
          ax = $rtoi(rx / len * 16384.0);
          ay = $rtoi(ry / len * 16384.0);
          az = $rtoi(rz / len * 16384.0);
          queue_req(ax, ay, az, $urandom);
          unit_axis_reqs++;
        end
        5, 6, 7: queue_req($urandom, $urandom, $urandom, $urandom);
        default: queue_req(edge_value(), edge_value(), edge_value(),
                           ($urandom_range(0, 1) == 0) ? edge_value() : $urandom);
      endcase
    end
    total_requests = pending_reqs.size();

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (requests_sent < total_requests) @(posedge clk);
    while (expected_mats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d requests (%0d unit axes), %0d matrices checked, %0d long hold-offs",
             requests_sent, unit_axis_reqs, results_seen, holds_done);
    $display("%0d entry mismatches", errors);
    if (errors == 0 && expected_mats.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
